@@ sv/vrc_pkg.sv @@
// shared constants, types and exp fraction table for the volume render compositor
package vrc_pkg;

    // field and arithmetic widths
    localparam int COLOR_BITS        = 16;
    localparam int FIELD_W           = 16;
    localparam int FRAC_W            = 16;
    localparam int Q_W               = FRAC_W + 1;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int IDX_W             = $clog2(EXP_TABLE_ENTRIES);
    localparam int IDX_PROD_W        = FRAC_W + IDX_W;
    localparam int PROD1_W           = 2 * FIELD_W;
    localparam int PROD2_W           = 3 * FIELD_W;
    localparam int X_SHIFT           = 12;
    localparam int X_W               = 20;
    localparam int LOG2E_W           = 17;
    localparam int Y_W               = X_W + LOG2E_W - FRAC_W;
    localparam int N_W               = Y_W - FRAC_W;
    localparam int SUM_W             = COLOR_BITS + 2;

    localparam logic [Q_W-1:0]     ONE_Q16   = Q_W'(1) << FRAC_W;
    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = LOG2E_W'(94548);
    localparam logic [N_W-1:0]     E_CUTOFF  = N_W'(17);
    localparam logic [63:0]        LN2_Q32   = 64'd2977044472;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((3 * FIELD_W + 3 * COLOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * COLOR_BITS + 7) / 8) * 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // back sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_WEIGHT,
        B_MIX,
        B_LAST,
        B_EMIT
    } back_state_t;

    // one unit of compositing work
    typedef struct packed {
        logic                  held_ok;
        logic [Q_W-1:0]        e;
        logic [COLOR_BITS-1:0] held_r;
        logic [COLOR_BITS-1:0] held_g;
        logic [COLOR_BITS-1:0] held_b;
        logic                  last;
        logic                  cur_nz;
        logic [COLOR_BITS-1:0] cur_r;
        logic [COLOR_BITS-1:0] cur_g;
        logic [COLOR_BITS-1:0] cur_b;
    } job_t;

    typedef logic [EXP_TABLE_ENTRIES-1:0][Q_W-1:0] exp_table_t;

    // round(65536 * 2^(-k/N)) from a Q0.32 series of exp(-k ln2 / N)
    function automatic exp_table_t build_exp_table();
        exp_table_t  tbl;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] even;
        logic [63:0] odd;
        logic [63:0] val;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            u    = (64'(k) * LN2_Q32) / 64'(EXP_TABLE_ENTRIES);
            term = 64'd1 << 32;
            even = term;
            odd  = '0;
            for (int j = 1; j <= 14; j++) begin
                term = ((term * u) >> 32) / 64'(j);
                if (j[0]) begin
                    odd = odd + term;
                end else begin
                    even = even + term;
                end
            end
            val    = ((even - odd) + 64'h8000) >> 16;
            tbl[k] = val[Q_W-1:0];
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ sv/vrc_front.sv @@
// front end: takes samples, holds the previous one and works out its exp(-x) term
module vrc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vrc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          job_valid,
    output vrc_pkg::job_t                 job,
    input  logic                          q_full
);

    localparam int FW  = vrc_pkg::FIELD_W;
    localparam int CB  = vrc_pkg::COLOR_BITS;
    localparam int OFF_R  = FW;
    localparam int OFF_G  = OFF_R + CB;
    localparam int OFF_B  = OFF_G + CB;
    localparam int OFF_D  = OFF_B + CB;
    localparam int OFF_RL = OFF_D + FW;
    localparam int X_SHIFT_C = vrc_pkg::X_SHIFT;

    logic [FW-1:0] in_density;
    logic [CB-1:0] in_red;
    logic [CB-1:0] in_green;
    logic [CB-1:0] in_blue;
    logic [FW-1:0] in_depth;
    logic [FW-1:0] in_ray_length;
    logic [FW-1:0] spacing;
    logic          accept;
    logic          advance;

    logic          held_valid_reg;
    logic [FW-1:0] held_density_reg;
    logic [CB-1:0] held_red_reg;
    logic [CB-1:0] held_green_reg;
    logic [CB-1:0] held_blue_reg;
    logic [FW-1:0] held_depth_reg;

    logic                           v1_reg, v2_reg, v3_reg, v4_reg;
    vrc_pkg::job_t                  j1_reg, j2_reg, j3_reg, j4_reg;
    logic [vrc_pkg::PROD1_W-1:0]    prod1_reg;
    logic [FW-1:0]                  rl1_reg;
    logic [vrc_pkg::X_W-1:0]        x2_reg;
    logic [vrc_pkg::Y_W-1:0]        y3_reg;

    logic [vrc_pkg::PROD2_W-1:0]              p_full;
    logic [vrc_pkg::PROD2_W-X_SHIFT_C-1:0]    x_full;
    logic [vrc_pkg::X_W-1:0]                  x_clamped;
    logic [vrc_pkg::X_W+vrc_pkg::LOG2E_W-1:0] y_full;
    logic [vrc_pkg::N_W-1:0]                  y_int;
    logic [vrc_pkg::FRAC_W-1:0]               y_frac;
    logic [vrc_pkg::IDX_PROD_W-1:0]           idx_prod;
    logic [vrc_pkg::IDX_W-1:0]                idx;
    logic [vrc_pkg::Q_W-1:0]                  e_val;
    vrc_pkg::job_t                            j_new;
    vrc_pkg::job_t                            j3_e;

    // field unpacking
    assign in_density    = s_tdata[FW-1:0];
    assign in_red        = s_tdata[OFF_R+CB-1:OFF_R];
    assign in_green      = s_tdata[OFF_G+CB-1:OFF_G];
    assign in_blue       = s_tdata[OFF_B+CB-1:OFF_B];
    assign in_depth      = s_tdata[OFF_D+FW-1:OFF_D];
    assign in_ray_length = s_tdata[OFF_RL+FW-1:OFF_RL];

    // whole pipeline moves unless the last stage is blocked by a full queue
    assign advance  = !v4_reg || !q_full;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // spacing to the held sample, zero when depth goes backwards
    assign spacing = (in_depth >= held_depth_reg) ? (in_depth - held_depth_reg) : '0;

    always_comb begin
        j_new         = '0;
        j_new.held_ok = held_valid_reg;
        j_new.held_r  = held_red_reg;
        j_new.held_g  = held_green_reg;
        j_new.held_b  = held_blue_reg;
        j_new.last    = s_tlast;
        j_new.cur_nz  = (in_density != '0);
        j_new.cur_r   = in_red;
        j_new.cur_g   = in_green;
        j_new.cur_b   = in_blue;
    end

    // optical depth, clamped where the exp term is already zero
    assign p_full    = vrc_pkg::PROD2_W'(prod1_reg) * vrc_pkg::PROD2_W'(rl1_reg);
    assign x_full    = p_full[vrc_pkg::PROD2_W-1:X_SHIFT_C];
    assign x_clamped = (|x_full[vrc_pkg::PROD2_W-X_SHIFT_C-1:vrc_pkg::X_W])
                     ? '1 : x_full[vrc_pkg::X_W-1:0];

    // scale to base two
    assign y_full = (vrc_pkg::X_W + vrc_pkg::LOG2E_W)'(x2_reg)
                  * (vrc_pkg::X_W + vrc_pkg::LOG2E_W)'(vrc_pkg::LOG2E_Q16);

    // 2^-y from table entry and integer shift
    assign y_int    = y3_reg[vrc_pkg::Y_W-1:vrc_pkg::FRAC_W];
    assign y_frac   = y3_reg[vrc_pkg::FRAC_W-1:0];
    assign idx_prod = vrc_pkg::IDX_PROD_W'(y_frac)
                    * vrc_pkg::IDX_PROD_W'(vrc_pkg::EXP_TABLE_ENTRIES);
    assign idx      = idx_prod[vrc_pkg::IDX_PROD_W-1:vrc_pkg::FRAC_W];
    assign e_val    = (y_int >= vrc_pkg::E_CUTOFF) ? '0 : (vrc_pkg::EXP_TABLE[idx] >> y_int);

    // third stage job with its exp term filled in
    always_comb begin
        j3_e   = j3_reg;
        j3_e.e = e_val;
    end

    // held sample register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
        end else if (accept) begin
            held_valid_reg <= !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_density_reg <= in_density;
            held_red_reg     <= in_red;
            held_green_reg   <= in_green;
            held_blue_reg    <= in_blue;
            held_depth_reg   <= in_depth;
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= accept && (held_valid_reg || s_tlast);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod1_reg <= vrc_pkg::PROD1_W'(held_density_reg) * vrc_pkg::PROD1_W'(spacing);
            rl1_reg   <= in_ray_length;
            j1_reg    <= j_new;
            x2_reg    <= x_clamped;
            j2_reg    <= j1_reg;
            y3_reg    <= y_full[vrc_pkg::X_W+vrc_pkg::LOG2E_W-1:vrc_pkg::FRAC_W];
            j3_reg    <= j2_reg;
            j4_reg    <= j3_e;
        end
    end

    assign job_valid = v4_reg;
    assign job       = j4_reg;

    // a stall can only come from a finished item facing a full queue
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v4_reg && q_full))
        else $error("front stalled without a blocked job");

endmodule

@@ sv/vrc_queue.sv @@
// short job queue between the front end and the compositing back end
module vrc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  vrc_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output vrc_pkg::job_t head,
    output logic          empty
);

    vrc_pkg::job_t                mem [vrc_pkg::QUEUE_DEPTH];
    logic [vrc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [vrc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [vrc_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [vrc_pkg::QPTR_W-1:0] LAST_PTR = vrc_pkg::QPTR_W'(vrc_pkg::QUEUE_DEPTH - 1);
    localparam logic [vrc_pkg::QCNT_W-1:0] FULL_CNT = vrc_pkg::QCNT_W'(vrc_pkg::QUEUE_DEPTH);
    localparam logic [vrc_pkg::QPTR_W-1:0] PTR_ONE  = vrc_pkg::QPTR_W'(1);
    localparam logic [vrc_pkg::QCNT_W-1:0] CNT_ONE  = vrc_pkg::QCNT_W'(1);

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_ONE;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_ONE;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job popped from empty queue");

endmodule

@@ sv/vrc_back.sv @@
// back end: composites queued jobs into colour sums and emits the pixel
module vrc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vrc_pkg::job_t                 head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vrc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CB   = vrc_pkg::COLOR_BITS;
    localparam int QW   = vrc_pkg::Q_W;
    localparam int SW   = vrc_pkg::SUM_W;
    localparam int FRW  = vrc_pkg::FRAC_W;

    vrc_pkg::back_state_t state_reg, state_next;
    vrc_pkg::job_t        job_reg;
    logic [QW-1:0]        t_reg;
    logic [QW-1:0]        w_reg;
    logic [SW-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic                 m_tvalid_reg;
    logic [CB-1:0]        pix_r_reg, pix_g_reg, pix_b_reg;

    logic [QW-1:0]        alpha;
    logic [2*QW-1:0]      w_prod;
    logic [2*QW-1:0]      t_prod;
    logic [QW-1:0]        mix_w;
    logic [CB-1:0]        mix_r, mix_g, mix_b;
    logic                 emit_fire;

    // weighted colour term, (w * c) >> 16
    function automatic logic [CB:0] mix_term(input logic [QW-1:0] w, input logic [CB-1:0] c);
        logic [QW+CB-1:0] prod;
        prod = (QW+CB)'(w) * (QW+CB)'(c);
        return prod[QW+CB-1:FRW];
    endfunction

    // saturating colour sum
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [CB:0] t);
        logic [SW:0] total;
        total = (SW+1)'(s) + (SW+1)'(t);
        return total[SW] ? '1 : total[SW-1:0];
    endfunction

    // clip a sum to full scale
    function automatic logic [CB-1:0] clip(input logic [SW-1:0] s);
        return (|s[SW-1:CB]) ? '1 : s[CB-1:0];
    endfunction

    // opacity and transmittance products
    assign alpha  = vrc_pkg::ONE_Q16 - job_reg.e;
    assign w_prod = (2*QW)'(alpha) * (2*QW)'(t_reg);
    assign t_prod = (2*QW)'(t_reg) * (2*QW)'(job_reg.e);

    // colour operands for the mix and last-sample steps
    always_comb begin
        if (state_reg == vrc_pkg::B_LAST) begin
            mix_w = job_reg.cur_nz ? t_reg : '0;
            mix_r = job_reg.cur_r;
            mix_g = job_reg.cur_g;
            mix_b = job_reg.cur_b;
        end else begin
            mix_w = w_reg;
            mix_r = job_reg.held_r;
            mix_g = job_reg.held_g;
            mix_b = job_reg.held_b;
        end
    end

    assign emit_fire = (state_reg == vrc_pkg::B_EMIT) && (!m_tvalid_reg || m_tready);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            vrc_pkg::B_IDLE: begin
                if (!q_empty) begin
                    pop = 1'b1;
                    if (head.held_ok) begin
                        state_next = vrc_pkg::B_WEIGHT;
                    end else if (head.last) begin
                        state_next = vrc_pkg::B_LAST;
                    end
                end
            end
            vrc_pkg::B_WEIGHT: begin
                state_next = vrc_pkg::B_MIX;
            end
            vrc_pkg::B_MIX: begin
                state_next = job_reg.last ? vrc_pkg::B_LAST : vrc_pkg::B_IDLE;
            end
            vrc_pkg::B_LAST: begin
                state_next = vrc_pkg::B_EMIT;
            end
            vrc_pkg::B_EMIT: begin
                if (emit_fire) begin
                    state_next = vrc_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = vrc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrc_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // job latch and weight register
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head;
        end
        if (state_reg == vrc_pkg::B_WEIGHT) begin
            w_reg <= w_prod[2*QW-2:FRW];
        end
    end

    // ray state: transmittance and colour sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg     <= vrc_pkg::ONE_Q16;
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end else if (emit_fire) begin
            t_reg     <= vrc_pkg::ONE_Q16;
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end else if (state_reg == vrc_pkg::B_WEIGHT) begin
            t_reg <= t_prod[2*QW-2:FRW];
        end else if (state_reg == vrc_pkg::B_MIX || state_reg == vrc_pkg::B_LAST) begin
            sum_r_reg <= sat_add(sum_r_reg, mix_term(mix_w, mix_r));
            sum_g_reg <= sat_add(sum_g_reg, mix_term(mix_w, mix_g));
            sum_b_reg <= sat_add(sum_b_reg, mix_term(mix_w, mix_b));
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            pix_r_reg <= clip(sum_r_reg);
            pix_g_reg <= clip(sum_g_reg);
            pix_b_reg <= clip(sum_b_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = vrc_pkg::M_TDATA_W'({pix_b_reg, pix_g_reg, pix_r_reg});

    a_t_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        t_reg <= vrc_pkg::ONE_Q16)
        else $error("transmittance above one");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (t_reg == vrc_pkg::ONE_Q16 && m_tvalid_reg && sum_r_reg == '0))
        else $error("ray state not cleared on emit");

endmodule

@@ sv/volume_render_compositor_core.sv @@
// volume render compositor top level: front end, job queue and back end
// front end takes one sample per cycle through a four-stage exp pipeline, unless a full queue stalls it
// back end sequencer steps through weight and mix for each sample that follows another, then last and emit per ray end
// sustained rate is therefore set by the back end sequencer
// reset (aresetn low, synchronous) empties the queue, drops the held sample, sets T to one
module volume_render_compositor_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // density, red, green, blue, depth, ray_length
    input  logic [vrc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_red, pixel_green, pixel_blue
    output logic [vrc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic          job_valid;
    vrc_pkg::job_t job;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    vrc_pkg::job_t q_head;

    // sample intake and exp term
    vrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (job_valid),
        .job       (job),
        .q_full    (q_full)
    );

    // decoupling queue
    vrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // compositing and pixel output
    vrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_empty  (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/sv/tb.sv @@
// testbench for the volume render compositor: ray sample streams checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          NUM_CHAN     = 3;

    // one ray sample as it crosses the slave side
    typedef struct packed {
        logic [15:0] density;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] depth;
        logic [15:0] ray_length;
        logic        last;
    } sample_t;

    // composited pixel, index 0 is red
    typedef logic [NUM_CHAN-1:0][vrc_pkg::COLOR_BITS-1:0] pixel_t;

    // predicts composited pixels and checks them in order
    class pixel_scoreboard;
        longint unsigned exp_frac[vrc_pkg::EXP_TABLE_ENTRIES];
        bit              held_valid;
        longint unsigned held_density;
        longint unsigned held_depth;
        longint unsigned held_colour[NUM_CHAN];
        longint unsigned trans;
        longint unsigned sums[NUM_CHAN];
        pixel_t          expected_pixels[$];
        int unsigned     mismatches;

        function new();
            longint unsigned u;
            longint unsigned term;
            longint unsigned even_sum;
            longint unsigned odd_sum;
            // 2^(-k/N) in Q1.16 from an alternating series of exp(-k ln2 / N) in Q0.32
            for (int k = 0; k < vrc_pkg::EXP_TABLE_ENTRIES; k++) begin
                u        = (longint'(k) * 64'd2977044472) / vrc_pkg::EXP_TABLE_ENTRIES;
                term     = 64'd1 << 32;
                even_sum = term;
                odd_sum  = 0;
                for (int j = 1; j <= 14; j++) begin
                    term = ((term * u) >> 32) / longint'(j);
                    if (j % 2 == 1) begin
                        odd_sum += term;
                    end else begin
                        even_sum += term;
                    end
                end
                exp_frac[k] = ((even_sum - odd_sum) + 64'h8000) >> 16;
            end
            mismatches = 0;
            clear_ray();
        endfunction

        function void clear_ray();
            held_valid   = 1'b0;
            held_density = 0;
            held_depth   = 0;
            trans        = 65536;
            for (int c = 0; c < NUM_CHAN; c++) begin
                held_colour[c] = 0;
                sums[c]        = 0;
            end
        endfunction

        // weighted colour into the sums, then attenuate transmittance
        function void blend(longint unsigned alpha, longint unsigned colour[NUM_CHAN]);
            longint unsigned w;
            w = (alpha * trans) >> 16;
            for (int c = 0; c < NUM_CHAN; c++) begin
                sums[c] += (w * colour[c]) >> 16;
                if (sums[c] > (64'd1 << vrc_pkg::SUM_W) - 1) begin
                    sums[c] = (64'd1 << vrc_pkg::SUM_W) - 1;
                end
            end
            trans = (trans * (65536 - alpha)) >> 16;
        endfunction

        // accepted sample: composite the held one, emit on the last
        function void note_sample(sample_t s);
            longint unsigned spacing;
            longint unsigned x;
            longint unsigned y;
            longint unsigned n;
            longint unsigned e;
            longint unsigned cur[NUM_CHAN];
            pixel_t          px;
            if (held_valid) begin
                spacing = (s.depth >= held_depth) ? s.depth - held_depth : 0;
                x       = (held_density * spacing * longint'(s.ray_length)) >> 12;
                y       = (x * 94548) >> 16;
                n       = y >> 16;
                if (n >= 17) begin
                    e = 0;
                end else begin
                    e = exp_frac[((y & 64'hFFFF) * vrc_pkg::EXP_TABLE_ENTRIES) >> 16] >> n;
                end
                blend(65536 - e, held_colour);
            end
            cur[0] = s.red;
            cur[1] = s.green;
            cur[2] = s.blue;
            if (s.last) begin
                // unbounded spacing: fully opaque unless empty
                blend((s.density != 0) ? 65536 : 0, cur);
                for (int c = 0; c < NUM_CHAN; c++) begin
                    px[c] = (sums[c] > 65535) ? 16'hFFFF : sums[c][15:0];
                end
                expected_pixels.insert(expected_pixels.size(), px);
                clear_ray();
            end else begin
                held_valid   = 1'b1;
                held_density = s.density;
                held_depth   = s.depth;
                held_colour  = cur;
            end
        endfunction

        function void check_pixel(logic [vrc_pkg::M_TDATA_W-1:0] data);
            string  names[NUM_CHAN];
            pixel_t want;
            names = '{"pixel_red", "pixel_green", "pixel_blue"};
            if (expected_pixels.size() == 0) begin
                $error("pixel with none expected: %h", data);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (data[c*16 +: 16] !== want[c]) begin
                    $error("%s expected %h actual %h", names[c], want[c], data[c*16 +: 16]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // density, red, green, blue, depth, ray_length
    logic [vrc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // pixel_red, pixel_green, pixel_blue
    logic [vrc_pkg::M_TDATA_W-1:0] m_tdata;

    pixel_scoreboard sb = new();
    int unsigned     send_idle_pct  = 19;
    int unsigned     recv_stall_pct = 63;
    int unsigned     items_sent     = 0;
    int unsigned     cycle_count    = 0;

    volume_render_compositor_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #CLK_HALF aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel(m_tdata);
        end
    end

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_sample(input sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.ray_length, s.depth, s.blue, s.green, s.red, s.density};
        s_tlast  <= s.last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_sample(s);
        items_sent++;
    endtask

    // one ray of random content; a few are deliberately malformed
    task automatic send_random_ray();
        int unsigned len;
        int unsigned style;
        int unsigned depth_now;
        int unsigned rl;
        sample_t     s;
        len       = $urandom_range(1, 8);
        style     = $urandom_range(0, 9);
        depth_now = $urandom_range(0, 16'h6000);
        rl        = (style == 1) ? $urandom_range(0, 16'hFFFF) : $urandom_range(16'h0400, 16'h3000);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       s.density = '0;
                1:       s.density = 16'($urandom_range(0, 16'hFFFF));
                2:       s.density = 16'($urandom_range(0, 15));
                default: s.density = 16'($urandom_range(0, 16'h0800));
            endcase
            s.red   = 16'($urandom_range(0, 16'hFFFF));
            s.green = 16'($urandom_range(0, 16'hFFFF));
            s.blue  = 16'($urandom_range(0, 16'hFFFF));
            if (style == 0) begin
                // broken ray: depth out of order, length varies
                s.depth      = 16'($urandom_range(0, 16'hFFFF));
                s.ray_length = 16'($urandom_range(0, 16'hFFFF));
            end else begin
                if ($urandom_range(0, 9) != 0) begin
                    depth_now += $urandom_range(0, 16'h0180);
                end
                if (depth_now > 16'hFFFF) begin
                    depth_now = 16'hFFFF;
                end
                s.depth      = depth_now[15:0];
                s.ray_length = rl[15:0];
            end
            s.last = (i == len - 1);
            send_sample(s);
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-sample rays: empty, opaque at full scale, barely dense
        send_sample('{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h1000, 1'b1});
        send_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
        send_sample('{16'h0001, 16'h5555, 16'hAAAA, 16'h0001, 16'h1234, 16'h0000, 1'b1});
        // unit density over unit spacing and unit length
        send_sample('{16'h0100, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h1000, 1'b0});
        send_sample('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0100, 16'h1000, 1'b1});
        // depth going backwards gives the held sample no opacity
        send_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h1000, 1'b0});
        send_sample('{16'h0200, 16'h4000, 16'h2000, 16'h1000, 16'h1000, 16'h1000, 1'b1});
        // zero ray length, then every extreme at once
        send_sample('{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0});
        send_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0});
        send_sample('{16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 16'hFFFF, 16'hFFFF, 1'b0});
        send_sample('{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
        // long ray of thin samples, with a repeated depth
        send_sample('{16'h0004, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 1'b0});
        send_sample('{16'h0010, 16'h0000, 16'hFFFF, 16'h0000, 16'h0040, 16'h1000, 1'b0});
        send_sample('{16'h0040, 16'h0000, 16'h0000, 16'hFFFF, 16'h0040, 16'h1000, 1'b0});
        send_sample('{16'h0100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0080, 16'h1000, 1'b0});
        send_sample('{16'h0800, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h00C0, 16'h1000, 1'b0});
        send_sample('{16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'h0100, 16'h1000, 1'b1});

        // random rays over three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 63 : 0;
            recv_stall_pct = (ph == 0) ? 63 : (ph == 1) ? 19 : 0;
            while (items_sent < (ph + 1) * PHASE_ITEMS) begin
                send_random_ray();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain, then watch for stray pixels
        while (sb.expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
